/* rtl/core/lph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Shared widths, codes and control types for the linear probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int KEY_W       = 16;
  localparam int SLOT_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic mod;
    logic probe;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic done;
  } stat_t;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert and search requests.
// ----------------------------------------------------------------------------
// channel   dir  tdata              tuser
// s_axis    in   key[15:0]          op[0]
// m_axis    out  slot_index[3:0]    status[1:0]
//
// A request is taken, reduced to its home slot and then probes P slots, P the
// number of slots probed (1..TABLE_SIZE), the slot memory read once per cycle.
// After reset a clearing pass over all TABLE_SIZE slots runs before the first
// request is taken.
// One request is in flight at a time; a held result stalls the next request
// only at its reduction step.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lph_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // key
  input  logic                             s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lph_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // slot_index, zero pad
  output logic [lph_pkg::STATUS_W-1:0]     m_axis_tuser    // status
);

  lph_pkg::cmd_t  cmd;
  lph_pkg::stat_t stat;

  lph_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lph_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule

/* rtl/core/lph_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer: clearing pass, request intake, home slot reduction, probing.
// ----------------------------------------------------------------------------
module lph_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  lph_pkg::stat_t stat,
  output lph_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        if (stat.out_free) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (stat.done) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  assign s_ready   = (state == S_IDLE);
  assign cmd.clr   = (state == S_CLR);
  assign cmd.load  = (state == S_IDLE) && s_valid;
  assign cmd.mul   = (state == S_MUL);
  assign cmd.mod   = (state == S_MOD) && stat.out_free;
  assign cmd.probe = (state == S_PROBE);

  a_load_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_MUL)
    else $error("accepted request did not move on to reduction");

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_PROBE)
    else $error("sequencer in an unused state");

  a_mod_then_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.mod |=> state == S_PROBE)
    else $error("reduction did not move on to probing");

endmodule

/* rtl/core/lph_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_dp
// Datapath: key store, used marks, home slot reduction, probe and result.
// ----------------------------------------------------------------------------
module lph_dp #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lph_pkg::cmd_t                    cmd,
  output lph_pkg::stat_t                   stat,
  input  logic [lph_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lph_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [lph_pkg::STATUS_W-1:0]     m_tuser
);

  localparam int KW = (KEY_BITS < lph_pkg::KEY_W) ? KEY_BITS : lph_pkg::KEY_W;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int SH = KW + AW + 1;
  localparam int PW = KW + SH;
  localparam int DW = (KW > AW + 1) ? KW : AW + 1;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / TABLE_SIZE);
  localparam logic [DW-1:0] T_D   = DW'(TABLE_SIZE);
  localparam logic [AW-1:0] T_LAST = AW'(TABLE_SIZE - 1);

  logic [KW-1:0] key_mem [TABLE_SIZE];
  logic          used_mem [TABLE_SIZE];

  logic          op_r;
  logic [KW-1:0] key_r;
  logic [KW-1:0] q_r;
  logic [PW-1:0] prod;
  logic [DW-1:0] qt;
  logic [DW-1:0] diff;
  logic [DW-1:0] home;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_inc;
  logic [AW-1:0] chk_addr;
  logic [AW-1:0] cnt;
  logic [AW-1:0] clr_addr;
  logic          data_vld;
  logic          used_q;
  logic [KW-1:0] key_q;
  logic          last;
  logic          done;
  logic          ins_wr;
  logic [lph_pkg::STATUS_W-1:0] res_status;
  logic [lph_pkg::SLOT_W-1:0]   res_slot;

  function automatic logic [AW-1:0] addr_clr_next(input logic [AW-1:0] a);
    addr_clr_next = (a == T_LAST) ? '0 : a + 1'b1;
  endfunction

  // quotient estimate by reciprocal, low by at most one
  assign prod = PW'(key_r) * PW'(RECIP);
  assign qt   = DW'(q_r) * T_D;
  assign diff = DW'(key_r) - qt;
  assign home = (diff >= T_D) ? diff - T_D : diff;

  assign addr_inc = (addr == T_LAST) ? '0 : addr + 1'b1;
  assign last     = (cnt == T_LAST);

  always_comb begin
    done       = 1'b0;
    ins_wr     = 1'b0;
    res_status = lph_pkg::ST_NOT_FOUND;
    res_slot   = '0;
    if (cmd.probe && data_vld) begin
      if (op_r == lph_pkg::OP_INSERT) begin
        priority if (!used_q) begin
          done       = 1'b1;
          ins_wr     = 1'b1;
          res_status = lph_pkg::ST_INSERTED;
          res_slot   = lph_pkg::SLOT_W'(chk_addr);
        end else if (last) begin
          done       = 1'b1;
          res_status = lph_pkg::ST_FULL;
        end else begin
          done       = 1'b0;
        end
      end else begin
        priority if (!used_q) begin
          done       = 1'b1;
          res_status = lph_pkg::ST_NOT_FOUND;
        end else if (key_q == key_r) begin
          done       = 1'b1;
          res_status = lph_pkg::ST_FOUND;
          res_slot   = lph_pkg::SLOT_W'(chk_addr);
        end else if (last) begin
          done       = 1'b1;
          res_status = lph_pkg::ST_NOT_FOUND;
        end else begin
          done       = 1'b0;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.clr_last = (clr_addr == T_LAST);

  // request and reduction registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= s_tuser;
      key_r <= s_tdata[KW-1:0];
    end
    if (cmd.mul) begin
      q_r <= prod[PW-1:SH];
    end
  end

  // probe sequencing: read one slot a cycle, check the one read before
  always_ff @(posedge clk) begin
    if (rst) begin
      data_vld <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= addr_clr_next(clr_addr);
      end
      if (cmd.mod) begin
        data_vld <= 1'b0;
      end else if (cmd.probe) begin
        data_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod) begin
      addr <= AW'(home);
      cnt  <= '0;
    end else if (cmd.probe) begin
      addr     <= addr_inc;
      chk_addr <= addr;
      if (data_vld) cnt <= cnt + 1'b1;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      used_mem[clr_addr] <= 1'b0;
    end else if (ins_wr) begin
      used_mem[chk_addr] <= 1'b1;
    end
    if (ins_wr) begin
      key_mem[chk_addr] <= key_r;
    end
    if (cmd.probe) begin
      used_q <= used_mem[addr];
      key_q  <= key_mem[addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= lph_pkg::OUT_TDATA_W'(res_slot);
      m_tuser <= res_status;
    end
  end

  a_out_free_at_done: assert property (@(posedge clk) disable iff (rst)
    done |-> (!m_tvalid || m_tready))
    else $error("result ready while output register still held");

  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> ((AW+1)'(addr) < (AW+1)'(TABLE_SIZE)))
    else $error("probe address beyond table");

  a_full_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (done && op_r == lph_pkg::OP_INSERT && used_q) |-> last)
    else $error("table full reported before every slot was probed");

endmodule
